// ===== rtl/core/kcs_pkg.sv =====
// Package for the keyframe channel sampler: constants, codes, lane control
// struct, the CORDIC arctangent table and the 32-bit saturation helper.
// Used by every module under rtl/core.
`default_nettype none

package kcs_pkg;

  localparam int DEF_MAX_KEYS     = 256;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int NUM_LANES        = 4;
  localparam int ONE_Q16          = 65536;
  localparam int CORDIC_STEPS     = 16;
  localparam int CORDIC_GAIN      = 39797;
  localparam int SIN_FLOOR        = 66;
  // CORDIC register width, sine width and lane operand width.
  localparam int CDW              = 24;
  localparam int SW               = 19;
  localparam int AW               = 33;

  typedef enum logic [1:0] {
    CMD_LOAD_TIME = 2'd0,
    CMD_LOAD_VEC  = 2'd1,
    CMD_SET_KIND  = 2'd2,
    CMD_SAMPLE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TRANS  = 2'd0,
    KIND_ORIENT = 2'd1,
    KIND_WEIGHT = 2'd2
  } kind_e;

  typedef enum logic {
    REG_MODE  = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_DOT   = 2'd0,
    OP_LERP  = 2'd1,
    OP_SLERP = 2'd2
  } lane_op_e;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_SUM, L_DIV, L_FIX, L_DONE
  } lane_state_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_FDIV, S_VRD0, S_VRD1, S_VRD2, S_DISP, S_DOT, S_COS,
    S_SQRT, S_SQD, S_ATAN, S_ANG, S_SIN1, S_SIN0, S_LANE, S_OUT
  } smp_state_e;

  typedef struct packed {
    logic     start;
    lane_op_e op;
  } lane_ctrl_t;

  function automatic logic signed [CDW-1:0] atan_entry(input logic [3:0] idx);
    logic signed [CDW-1:0] v;
    unique case (idx)
      4'd0:  v = CDW'(51472);
      4'd1:  v = CDW'(30386);
      4'd2:  v = CDW'(16055);
      4'd3:  v = CDW'(8150);
      4'd4:  v = CDW'(4091);
      4'd5:  v = CDW'(2047);
      4'd6:  v = CDW'(1024);
      4'd7:  v = CDW'(512);
      4'd8:  v = CDW'(256);
      4'd9:  v = CDW'(128);
      4'd10: v = CDW'(64);
      4'd11: v = CDW'(32);
      4'd12: v = CDW'(16);
      4'd13: v = CDW'(8);
      4'd14: v = CDW'(4);
      4'd15: v = CDW'(2);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kcs_cordic.sv =====
// Iterative 16-step CORDIC, one step per cycle, in vectoring mode (angle of
// a vector) or rotation mode (sine of an angle). Depends on kcs_pkg.
`default_nettype none

module kcs_cordic
  import kcs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  vec_i,
  input  wire logic signed [CDW-1:0] x_i,
  input  wire logic signed [CDW-1:0] y_i,
  input  wire logic signed [CDW-1:0] z_i,
  output logic                       done_o,
  output logic signed [CDW-1:0]      y_o,
  output logic signed [CDW-1:0]      z_o
);

  logic                  busy_q, done_q, vec_q;
  logic [3:0]            i_q;
  logic signed [CDW-1:0] x_q, y_q, z_q;
  logic signed [CDW-1:0] x_d, y_d, z_d, xs, ys;
  logic                  pos;

  always_comb begin
    xs  = x_q >>> i_q;
    ys  = y_q >>> i_q;
    pos = vec_q ? !(y_q > 0) : (z_q >= 0);
    if (pos) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - atan_entry(i_q);
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + atan_entry(i_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 4'd1;
        if (i_q == 4'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vec_q <= vec_i;
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("cordic started while busy");

endmodule

`default_nettype wire

// ===== rtl/core/kcs_lane.sv =====
// One arithmetic lane: dot-product term, linear blend, or the slerp weighted
// sum followed by a bit-serial signed division. Depends on kcs_pkg.
`default_nettype none

module kcs_lane
  import kcs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lane_ctrl_t           ctrl_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [31:0]   b_i,
  input  wire logic [16:0]          f_i,
  input  wire logic signed [SW-1:0] s0_i,
  input  wire logic signed [SW-1:0] s1_i,
  input  wire logic [16:0]          s_i,
  output logic                      done_o,
  output logic signed [48:0]        term_o,
  output logic signed [31:0]        res_o
);

  localparam int DW  = 53;
  localparam int DCW = $clog2(DW);

  lane_state_e state_q, state_d;
  lane_op_e    op_q;
  logic signed [AW-1:0] a_q;
  logic signed [31:0]   b_q;
  logic [16:0]          f_q, s_q;
  logic signed [SW-1:0] s0_q, s1_q;
  logic signed [64:0]   p0_q, p0_d;
  logic signed [50:0]   p1_q;
  logic signed [48:0]   term_q;
  logic signed [31:0]   res_q;
  logic                 neg_q;
  logic [DW-1:0]        num_q;
  logic [17:0]          rem_q;
  logic [DCW-1:0]       cnt_q;

  logic signed [33:0] diff;
  logic signed [17:0] fs;
  logic signed [64:0] prod_dot;
  logic signed [51:0] prod_lerp, prod_s0;
  logic signed [50:0] prod_s1;
  logic signed [52:0] wsum;
  logic signed [36:0] lerp_sum;
  logic [18:0]        rem2;
  logic               ge;
  logic signed [53:0] quot;

  always_comb begin
    diff      = $signed({{2{b_q[31]}}, b_q}) - $signed({a_q[AW-1], a_q});
    fs        = $signed({1'b0, f_q});
    prod_dot  = a_q * b_q;
    prod_lerp = diff * fs;
    prod_s0   = a_q * s0_q;
    prod_s1   = b_q * s1_q;
    unique case (op_q)
      OP_DOT:   p0_d = prod_dot;
      OP_LERP:  p0_d = 65'(prod_lerp);
      OP_SLERP: p0_d = 65'(prod_s0);
      default:  p0_d = prod_dot;
    endcase
    wsum     = 53'($signed(p0_q[51:0])) + 53'(p1_q);
    lerp_sum = 37'(a_q) + 37'($signed(p0_q[51:16]));
    rem2     = {rem_q, num_q[DW-1]};
    ge       = rem2 >= {2'b00, s_q};
    quot     = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (ctrl_i.start) state_d = L_MUL;
      L_MUL:  state_d = L_SUM;
      L_SUM:  state_d = (op_q == OP_SLERP) ? L_DIV : L_DONE;
      L_DIV:  if (cnt_q == DCW'(DW - 1)) state_d = L_FIX;
      L_FIX:  state_d = L_DONE;
      L_DONE: state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      L_IDLE: begin
        if (ctrl_i.start) begin
          op_q <= ctrl_i.op;
          a_q  <= a_i;
          b_q  <= b_i;
          f_q  <= f_i;
          s0_q <= s0_i;
          s1_q <= s1_i;
          s_q  <= s_i;
        end
      end
      L_MUL: begin
        p0_q <= p0_d;
        p1_q <= prod_s1;
      end
      L_SUM: begin
        term_q <= p0_q[64:16];
        res_q  <= sat32(64'(lerp_sum));
        neg_q  <= wsum < 0;
        num_q  <= (wsum < 0) ? DW'(-wsum) : DW'(wsum);
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      L_DIV: begin
        rem_q <= ge ? 18'(rem2 - {2'b00, s_q}) : rem2[17:0];
        num_q <= {num_q[DW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      L_FIX: res_q <= sat32(64'(quot));
      default: ;
    endcase
  end

  always_comb begin
    done_o = (state_q == L_DONE);
    term_o = term_q;
    res_o  = res_q;
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> (state_q == L_IDLE))
    else $error("lane started while busy");

endmodule

`default_nettype wire

// ===== rtl/core/keyframe_channel_sampler.sv =====
// Top level of the keyframe channel sampler: command decode, key tables,
// segment search, fraction and square root units, and merging of the lanes.
// Depends on kcs_pkg, kcs_lane and kcs_cordic.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  cfg     | in        | psel/penable/pready| paddr, pwdata, prdata
//  in      | in        | in_valid/in_stall  | command .. weight_width
//  out     | out       | out_valid/out_stall| out_lane0..3, base_key, ...
//
// A sample scans the K key times, one key time read per cycle, then runs the
// bit-serial fraction divider, and a linear blend adds a lane pass; an
// orientation slerp adds the square root, three 16-step CORDIC passes and the
// 53-step lane dividers. Reset clears control state and sets every channel to
// translation with three lanes; key tables are not cleared.
// A finished word waits in the output register while stalled.
`default_nettype none

module keyframe_channel_sampler
  import kcs_pkg::*;
#(
  parameter int MAX_KEYS     = DEF_MAX_KEYS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [7:0]         key_slot_i,
  input  wire logic [3:0]         channel_sel_i,
  input  wire logic signed [31:0] sample_time_i,
  input  wire logic signed [31:0] value_a_i,
  input  wire logic signed [31:0] value_b_i,
  input  wire logic signed [31:0] value_c_i,
  input  wire logic signed [31:0] value_d_i,
  input  wire logic [1:0]         kind_value_i,
  input  wire logic [2:0]         weight_width_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      out_lane0_o,
  output logic signed [31:0]      out_lane1_o,
  output logic signed [31:0]      out_lane2_o,
  output logic signed [31:0]      out_lane3_o,
  output logic [7:0]              base_key_o,
  output logic [16:0]             blend_fraction_o,
  output logic [2:0]              lanes_valid_o
);

  localparam int KW  = $clog2(MAX_KEYS);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int VD  = MAX_CHANNELS * MAX_KEYS;
  localparam int VAW = $clog2(VD);

  // Configuration registers.
  logic       mode_q;
  logic [8:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      count_q <= 9'd2;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_MODE:  mode_q  <= pwdata[0];
        REG_COUNT: count_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pready = 1'b1;
    unique case (reg_idx_e'(paddr[2]))
      REG_MODE:  prdata = {31'd0, mode_q};
      REG_COUNT: prdata = {23'd0, count_q};
      default:   prdata = '0;
    endcase
  end

  // Command decode.
  smp_state_e state_q, state_d;
  logic in_acc, ch_ok, slot_ok;
  logic [CHW-1:0] chi;
  logic [KW-1:0]  sloti;

  always_comb begin
    in_acc  = in_valid_i && (state_q == S_IDLE);
    ch_ok   = int'(channel_sel_i) < MAX_CHANNELS;
    slot_ok = int'(key_slot_i) < MAX_KEYS;
    chi     = CHW'(channel_sel_i);
    sloti   = KW'(key_slot_i);
  end

  // Channel kinds.
  kind_e      kind_q  [MAX_CHANNELS];
  logic [2:0] width_q [MAX_CHANNELS];
  logic [2:0] ww_sat;

  always_comb begin
    if (weight_width_i == 3'd0) begin
      ww_sat = 3'd1;
    end else if (weight_width_i > 3'd4) begin
      ww_sat = 3'd4;
    end else begin
      ww_sat = weight_width_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        kind_q[k]  <= KIND_TRANS;
        width_q[k] <= 3'd3;
      end
    end else if (in_acc && command_i == CMD_SET_KIND && ch_ok && kind_value_i != 2'd3) begin
      kind_q[chi] <= kind_e'(kind_value_i);
      unique case (kind_e'(kind_value_i))
        KIND_TRANS:  width_q[chi] <= 3'd3;
        KIND_ORIENT: width_q[chi] <= 3'd4;
        KIND_WEIGHT: width_q[chi] <= ww_sat;
        default: ;
      endcase
    end
  end

  // Key time memory.
  logic [31:0]   tmem [MAX_KEYS];
  logic [31:0]   tdata_q;
  logic [KW-1:0] traddr;

  always_ff @(posedge clk_i) begin
    if (in_acc && command_i == CMD_LOAD_TIME && slot_ok) begin
      tmem[sloti] <= sample_time_i;
    end
    tdata_q <= tmem[traddr];
  end

  // Key vector memory.
  logic [127:0]   vmem [VD];
  logic [127:0]   vdata_q;
  logic [VAW-1:0] vraddr, vwaddr;
  logic [KW-1:0]  base_q;
  logic [CHW-1:0] ch_q;

  always_comb begin
    vwaddr = VAW'(int'(chi) * MAX_KEYS + int'(sloti));
    if (state_q == S_VRD1) begin
      vraddr = VAW'(int'(ch_q) * MAX_KEYS + int'(base_q) + 1);
    end else begin
      vraddr = VAW'(int'(ch_q) * MAX_KEYS + int'(base_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && command_i == CMD_LOAD_VEC && slot_ok && ch_ok) begin
      vmem[vwaddr] <= {value_d_i, value_c_i, value_b_i, value_a_i};
    end
    vdata_q <= vmem[vraddr];
  end

  // Sample datapath registers.
  logic [KW-1:0]      i_q, last_idx;
  logic signed [31:0] t_q, prev_q;
  kind_e              ckind_q;
  logic [2:0]         cwidth_q;
  logic [16:0]        frac_q;
  logic signed [32:0] den_q;
  logic [33:0]        frem_q;
  logic [3:0]         fcnt_q;
  logic [127:0]       x0_q, x1_q;
  logic signed [31:0] res_q [NUM_LANES];
  logic signed [50:0] c_q;
  logic               qneg_q;
  logic [16:0]        cabs_q, sroot_q;
  logic [33:0]        sqv_q;
  logic [17:0]        srem_q;
  logic [4:0]         scnt_q;
  logic signed [CDW-1:0] th_q, a0_q;
  logic signed [SW-1:0]  s1_q;

  logic               hit, big_cos;
  logic signed [32:0] num_c, den_c;
  logic [33:0]        frem2;
  logic               fge;
  logic signed [50:0] c_d;
  logic [16:0]        cabs_c;
  logic [33:0]        csq;
  logic [19:0]        srem2, strial;
  logic               sge;
  logic signed [41:0] ang1, ang0;

  // Lane and CORDIC hookup.
  lane_ctrl_t            lane_ctrl;
  logic [NUM_LANES-1:0]  lane_done;
  logic signed [48:0]    lane_term [NUM_LANES];
  logic signed [31:0]    lane_res  [NUM_LANES];
  logic                  cor_start, cor_vec, cor_done;
  logic signed [CDW-1:0] cor_x, cor_y, cor_z, cor_yo, cor_zo;

  always_comb begin
    if (count_q < 9'd2) begin
      last_idx = KW'(1);
    end else if (int'(count_q) > MAX_KEYS) begin
      last_idx = KW'(MAX_KEYS - 1);
    end else begin
      last_idx = KW'(count_q - 9'd1);
    end
    hit     = ($signed(tdata_q) > t_q) || (i_q == last_idx);
    num_c   = $signed({t_q[31], t_q}) - $signed({prev_q[31], prev_q});
    den_c   = $signed({tdata_q[31], tdata_q}) - $signed({prev_q[31], prev_q});
    frem2   = {frem_q[32:0], 1'b0};
    fge     = frem2 >= {1'b0, den_q};
    c_d     = 51'(lane_term[0]) + 51'(lane_term[1]) + 51'(lane_term[2]) + 51'(lane_term[3]);
    big_cos = (c_q >= 51'sd65536) || (c_q <= -51'sd65536);
    cabs_c  = (c_q < 0) ? 17'(-c_q) : 17'(c_q);
    csq     = cabs_c * cabs_c;
    srem2   = {srem_q, sqv_q[33:32]};
    strial  = {1'b0, sroot_q, 2'b01};
    sge     = srem2 >= strial;
    ang1    = $signed({1'b0, frac_q}) * th_q;
    ang0    = $signed({1'b0, 17'(ONE_Q16) - frac_q}) * th_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && command_i == CMD_SAMPLE && ch_ok) state_d = S_SCAN;
      S_SCAN: begin
        if (hit) begin
          if (i_q == '0 || den_c <= 0 || num_c >= den_c) begin
            state_d = S_VRD0;
          end else begin
            state_d = S_FDIV;
          end
        end
      end
      S_FDIV: if (fcnt_q == 4'd15) state_d = S_VRD0;
      S_VRD0: state_d = S_VRD1;
      S_VRD1: state_d = S_VRD2;
      S_VRD2: state_d = S_DISP;
      S_DISP: begin
        priority if (!mode_q) state_d = S_OUT;
        else if (ckind_q == KIND_ORIENT) state_d = S_DOT;
        else state_d = S_LANE;
      end
      S_DOT:  if (&lane_done) state_d = S_COS;
      S_COS:  state_d = big_cos ? S_OUT : S_SQRT;
      S_SQRT: if (scnt_q == 5'd16) state_d = S_SQD;
      S_SQD:  state_d = (sroot_q < 17'(SIN_FLOOR)) ? S_LANE : S_ATAN;
      S_ATAN: if (cor_done) state_d = S_ANG;
      S_ANG:  state_d = S_SIN1;
      S_SIN1: if (cor_done) state_d = S_SIN0;
      S_SIN0: if (cor_done) state_d = S_LANE;
      S_LANE: if (&lane_done) state_d = S_OUT;
      S_OUT:  if (!out_valid_o || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall_o     = (state_q != S_IDLE);
    traddr         = (state_q == S_SCAN) ? KW'(i_q + 1'b1) : '0;
    lane_ctrl.start = 1'b0;
    lane_ctrl.op    = OP_LERP;
    cor_start      = 1'b0;
    cor_vec        = 1'b0;
    cor_x          = CDW'(CORDIC_GAIN);
    cor_y          = '0;
    cor_z          = a0_q;
    unique case (state_q)
      S_DISP: begin
        lane_ctrl.start = mode_q;
        lane_ctrl.op    = (ckind_q == KIND_ORIENT) ? OP_DOT : OP_LERP;
      end
      S_SQD: begin
        if (sroot_q < 17'(SIN_FLOOR)) begin
          lane_ctrl.start = 1'b1;
        end else begin
          cor_start = 1'b1;
          cor_vec   = 1'b1;
          cor_x     = CDW'(cabs_q);
          cor_y     = CDW'(sroot_q);
          cor_z     = '0;
        end
      end
      S_ANG: begin
        cor_start = 1'b1;
        cor_z     = ang1[CDW+15:16];
      end
      S_SIN1: cor_start = cor_done;
      S_SIN0: begin
        lane_ctrl.start = cor_done;
        lane_ctrl.op    = OP_SLERP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        t_q      <= sample_time_i;
        ch_q     <= chi;
        ckind_q  <= kind_q[chi];
        cwidth_q <= width_q[chi];
        i_q      <= '0;
        qneg_q   <= 1'b0;
      end
      S_SCAN: begin
        prev_q <= tdata_q;
        i_q    <= KW'(i_q + 1'b1);
        if (hit) begin
          base_q <= (i_q == '0) ? '0 : KW'(i_q - 1'b1);
          frac_q <= (i_q == '0) ? '0 : ((den_c <= 0 || num_c >= den_c) ? 17'(ONE_Q16) : '0);
          den_q  <= den_c;
          frem_q <= {1'b0, num_c};
          fcnt_q <= '0;
        end
      end
      S_FDIV: begin
        frem_q <= fge ? 34'(frem2 - {1'b0, den_q}) : frem2;
        frac_q <= {frac_q[15:0], fge};
        fcnt_q <= fcnt_q + 4'd1;
      end
      S_VRD1: x0_q <= vdata_q;
      S_VRD2: x1_q <= vdata_q;
      S_DISP: begin
        for (int k = 0; k < NUM_LANES; k++) res_q[k] <= x0_q[32*k +: 32];
      end
      S_DOT: c_q <= c_d;
      S_COS: begin
        for (int k = 0; k < NUM_LANES; k++) res_q[k] <= x0_q[32*k +: 32];
        qneg_q  <= c_q < 0;
        cabs_q  <= cabs_c;
        sqv_q   <= 34'h1_0000_0000 - csq;
        srem_q  <= '0;
        sroot_q <= '0;
        scnt_q  <= '0;
      end
      S_SQRT: begin
        srem_q  <= sge ? 18'(srem2 - strial) : srem2[17:0];
        sroot_q <= {sroot_q[15:0], sge};
        sqv_q   <= {sqv_q[31:0], 2'b00};
        scnt_q  <= scnt_q + 5'd1;
      end
      S_ATAN: th_q <= cor_zo;
      S_ANG:  a0_q <= ang0[CDW+15:16];
      S_SIN1: if (cor_done) s1_q <= cor_yo[SW-1:0];
      S_LANE: begin
        for (int k = 0; k < NUM_LANES; k++) res_q[k] <= lane_res[k];
      end
      default: ;
    endcase
  end

  // Lanes.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic signed [AW-1:0] a_op;
    logic signed [AW-1:0] x0e;
    assign x0e  = $signed({x0_q[32*g+31], x0_q[32*g +: 32]});
    assign a_op = qneg_q ? -x0e : x0e;

    kcs_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .a_i    (a_op),
      .b_i    ($signed(x1_q[32*g +: 32])),
      .f_i    (frac_q),
      .s0_i   (cor_yo[SW-1:0]),
      .s1_i   (s1_q),
      .s_i    (sroot_q),
      .done_o (lane_done[g]),
      .term_o (lane_term[g]),
      .res_o  (lane_res[g])
    );
  end

  kcs_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .vec_i   (cor_vec),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .z_i     (cor_z),
    .done_o  (cor_done),
    .y_o     (cor_yo),
    .z_o     (cor_zo)
  );

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] out_lane_q [NUM_LANES];
  logic [7:0]         out_base_q;
  logic [16:0]        out_frac_q;
  logic [2:0]         out_width_q;
  logic               out_load;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        out_lane_q[k] <= (3'(k) < cwidth_q) ? res_q[k] : '0;
      end
      out_base_q  <= 8'(base_q);
      out_frac_q  <= frac_q;
      out_width_q <= cwidth_q;
    end
  end

  always_comb begin
    out_valid_o      = out_valid_q;
    out_lane0_o      = out_lane_q[0];
    out_lane1_o      = out_lane_q[1];
    out_lane2_o      = out_lane_q[2];
    out_lane3_o      = out_lane_q[3];
    base_key_o       = out_base_q;
    blend_fraction_o = out_frac_q;
    lanes_valid_o    = out_width_q;
  end

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (i_q <= last_idx))
    else $error("segment scan ran past the last key");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i == CMD_SAMPLE && ch_ok) |=> in_stall_o)
    else $error("sample word did not hold off the input");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (frac_q <= 17'(ONE_Q16)))
    else $error("blend fraction above one");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for keyframe_channel_sampler: fills the key tables, runs a directed
// table, then randomized phases over several mode and keyframe-count settings.
// Depends on kcs_pkg and the RTL under rtl/core; expected words come from a local predictor.
`timescale 1ns / 100ps

module tb;
  import kcs_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int HOLD_CYCLES  = 2000;

  typedef struct {
    cmd_e               cmd;
    logic [7:0]         slot;
    logic [3:0]         ch;
    logic signed [31:0] t;
    logic signed [31:0] v [4];
    logic [1:0]         kind;
    logic [2:0]         ww;
  } word_t;

  typedef struct {
    logic signed [31:0] lane [4];
    logic [7:0]         base;
    logic [16:0]        frac;
    logic [2:0]         nl;
  } sample_t;

  typedef struct {
    word_t   w;
    bit      known;
    sample_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic [1:0] command = '0;
  logic [7:0] key_slot = '0;
  logic [3:0] channel_sel = '0;
  logic signed [31:0] sample_time = '0, value_a = '0, value_b = '0, value_c = '0, value_d = '0;
  logic [1:0] kind_value = '0;
  logic [2:0] weight_width = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic signed [31:0] out_lane0_o, out_lane1_o, out_lane2_o, out_lane3_o;
  logic [7:0] base_key_o;
  logic [16:0] blend_fraction_o;
  logic [2:0] lanes_valid_o;

  keyframe_channel_sampler uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i(in_valid), .in_stall_o, .command_i(command), .key_slot_i(key_slot),
    .channel_sel_i(channel_sel), .sample_time_i(sample_time), .value_a_i(value_a),
    .value_b_i(value_b), .value_c_i(value_c), .value_d_i(value_d),
    .kind_value_i(kind_value), .weight_width_i(weight_width), .out_valid_o,
    .out_stall_i(out_stall), .out_lane0_o, .out_lane1_o, .out_lane2_o, .out_lane3_o,
    .base_key_o, .blend_fraction_o, .lanes_valid_o
  );

  always #10 clk_i = ~clk_i;

  // Predictor state.
  longint key_time [256];
  longint key_vec [16][256][4];
  kind_e  chan_kind [16];
  int     chan_lanes [16];
  int     mode_q, count_q;
  const longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2};

  sample_t pending_samples [$];
  int mismatches = 0;
  int snd_idle = 19, rcv_idle = 59;
  int cyc = 0;
  int hold_from = -HOLD_CYCLES - 1;

  function automatic longint sat32_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lerp_q(longint a, longint b, longint f);
    return sat32_q(a + (((b - a) * f) >>> 16));
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q16[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q16[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint rot_sine(longint a);
    longint x, y, z, nx, ny;
    x = CORDIC_GAIN; y = 0; z = a;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q16[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q16[i];
      end
      x = nx; y = ny;
    end
    return y;
  endfunction

  function automatic void slerp_q(input longint q [4], input longint r [4], input longint f,
                                  output longint res [4]);
    longint c, s, th, s0, s1;
    longint q1 [4];
    c = 0;
    for (int i = 0; i < 4; i++) begin
      q1[i] = q[i];
      c += (q[i] * r[i]) >>> 16;
    end
    if (c >= ONE_Q16 || c <= -ONE_Q16) begin
      res = q;
      return;
    end
    // Take the short way round.
    if (c < 0) begin
      for (int i = 0; i < 4; i++) q1[i] = -q1[i];
      c = -c;
    end
    s = root64(64'h1_0000_0000 - longint'(c * c));
    if (s < SIN_FLOOR) begin
      for (int i = 0; i < 4; i++) res[i] = lerp_q(q1[i], r[i], f);
      return;
    end
    th = vec_angle(s, c);
    s1 = rot_sine((f * th) >>> 16);
    s0 = rot_sine(((ONE_Q16 - f) * th) >>> 16);
    for (int i = 0; i < 4; i++) res[i] = sat32_q((q1[i] * s0 + r[i] * s1) / s);
  endfunction

  // Updates the predictor with one accepted word; returns 1 with the expected sample.
  function automatic bit predict_word(input word_t w, output sample_t o);
    int cnt, j, base;
    longint t, frac, num, den;
    longint x0 [4], x1 [4], res [4];
    o = '{default: '0};
    case (w.cmd)
      CMD_LOAD_TIME: key_time[w.slot] = w.t;
      CMD_LOAD_VEC: for (int i = 0; i < 4; i++) key_vec[w.ch][w.slot][i] = w.v[i];
      CMD_SET_KIND: begin
        if (w.kind != 2'd3) begin
          chan_kind[w.ch] = kind_e'(w.kind);
          if (w.kind == KIND_TRANS) chan_lanes[w.ch] = 3;
          else if (w.kind == KIND_ORIENT) chan_lanes[w.ch] = 4;
          else chan_lanes[w.ch] = (w.ww < 1) ? 1 : ((w.ww > 4) ? 4 : int'(w.ww));
        end
      end
      default: begin
        t = w.t;
        cnt = (count_q < 2) ? 2 : ((count_q > 256) ? 256 : count_q);
        j = cnt - 1;
        for (int i = 0; i + 1 < cnt; i++) begin
          if (key_time[i] > t) begin
            j = i;
            break;
          end
        end
        if (j == 0) begin
          base = 0; frac = 0;
        end else begin
          base = j - 1;
          num = t - key_time[base];
          den = key_time[j] - key_time[base];
          frac = (den <= 0 || num >= den) ? ONE_Q16 : (num * ONE_Q16) / den;
        end
        for (int i = 0; i < 4; i++) begin
          x0[i] = key_vec[w.ch][base][i];
          x1[i] = key_vec[w.ch][base + 1][i];
        end
        if (mode_q == 0) res = x0;
        else if (chan_kind[w.ch] == KIND_ORIENT) slerp_q(x0, x1, frac, res);
        else for (int i = 0; i < 4; i++) res[i] = lerp_q(x0[i], x1[i], frac);
        for (int i = 0; i < 4; i++) o.lane[i] = (i < chan_lanes[w.ch]) ? res[i][31:0] : '0;
        o.base = base[7:0];
        o.frac = frac[16:0];
        o.nl = chan_lanes[w.ch][2:0];
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Checks every word leaving the block against the oldest expectation.
  always @(posedge clk_i) begin
    sample_t e;
    if (out_valid_o && !out_stall) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word at cycle %0d", cyc);
      end else begin
        e = pending_samples.pop_front();
        if (e.lane[0] !== out_lane0_o || e.lane[1] !== out_lane1_o ||
            e.lane[2] !== out_lane2_o || e.lane[3] !== out_lane3_o ||
            e.base !== base_key_o || e.frac !== blend_fraction_o || e.nl !== lanes_valid_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cycle %0d: exp %h %h %h %h b%0d f%0d n%0d got %h %h %h %h b%0d f%0d n%0d",
                     cyc, e.lane[0], e.lane[1], e.lane[2], e.lane[3], e.base, e.frac, e.nl,
                     out_lane0_o, out_lane1_o, out_lane2_o, out_lane3_o, base_key_o,
                     blend_fraction_o, lanes_valid_o);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off window counted here.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= hold_from && cyc < hold_from + HOLD_CYCLES) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < rcv_idle);
    if (cyc > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(input word_t w, input bit known = 1'b0,
                           input sample_t typed = '{default: '0});
    sample_t e;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < snd_idle) @(posedge clk_i);
    end
    command <= w.cmd; key_slot <= w.slot; channel_sel <= w.ch; sample_time <= w.t;
    value_a <= w.v[0]; value_b <= w.v[1]; value_c <= w.v[2]; value_d <= w.v[3];
    kind_value <= w.kind; weight_width <= w.ww;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_word(w, e)) pending_samples.push_back(known ? typed : e);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e r, input int v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (r == REG_MODE) mode_q = v & 1;
    else count_q = v & 32'h1FF;
  endtask

  function automatic word_t mk(cmd_e c, int slot, int ch, longint t,
                               longint a = 0, longint b = 0, longint cc = 0, longint d = 0,
                               int kind = 0, int ww = 0);
    word_t w;
    w.cmd = c; w.slot = slot[7:0]; w.ch = ch[3:0]; w.t = t[31:0];
    w.v[0] = a[31:0]; w.v[1] = b[31:0]; w.v[2] = cc[31:0]; w.v[3] = d[31:0];
    w.kind = kind[1:0]; w.ww = ww[2:0];
    return w;
  endfunction

  function automatic sample_t res(longint a, longint b, longint c, longint d, int base,
                                  int frac, int nl);
    sample_t r;
    r.lane[0] = a[31:0]; r.lane[1] = b[31:0]; r.lane[2] = c[31:0]; r.lane[3] = d[31:0];
    r.base = base[7:0]; r.frac = frac[16:0]; r.nl = nl[2:0];
    return r;
  endfunction

  function automatic longint rnd_value();
    case ($urandom_range(3))
      0: return longint'($signed($urandom()));
      3: case ($urandom_range(3))
           0: return -64'sd2147483648;
           1: return 64'sd2147483647;
           2: return 0;
           default: return -1;
         endcase
      default: return longint'($urandom_range(90000)) - 45000;
    endcase
  endfunction

  function automatic word_t rnd_vec(int slot, int ch);
    return mk(CMD_LOAD_VEC, slot, ch, $signed($urandom()), rnd_value(), rnd_value(),
              rnd_value(), rnd_value());
  endfunction

  initial begin
    row_t table_q [$];
    int phase_mode [8] = '{1, 0, 1, 0, 1, 1, 1, 0};
    int phase_cnt  [8] = '{4, 256, 17, 2, 256, 1, 3, 9};
    int phase_len  [8] = '{100, 20, 100, 60, 20, 40, 80, 80};
    int n, k, sel;
    longint tt;
    word_t w;

    for (int c = 0; c < 16; c++) begin
      chan_kind[c] = KIND_TRANS;
      chan_lanes[c] = 3;
    end
    mode_q = 1;
    count_q = 2;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every table entry is written before anything can read it.
    for (int s = 0; s < 256; s++)
      send_word(mk(CMD_LOAD_TIME, s, 0, longint'(s) * 32'h8000 + $urandom_range(4096)));
    for (int c = 0; c < 16; c++)
      for (int s = 0; s < 256; s++) send_word(rnd_vec(s, c));

    table_q.push_back('{mk(CMD_LOAD_TIME, 0, 0, 0), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_LOAD_TIME, 1, 0, 32'h10000), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_LOAD_VEC, 0, 0, 0, 0, 0, 0, 0), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_LOAD_VEC, 1, 0, 0, 32'h10000, 32'h20000, -32'sh10000,
                           32'h7fffffff), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 0, 32'h8000), 1,
                        res(32'h8000, 32'h10000, -32'sh8000, 0, 0, 32'h8000, 3)});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 0, -64'sd2147483648), 1, res(0, 0, 0, 0, 0, 0, 3)});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 0, 64'sd2147483647), 1,
                        res(32'h10000, 32'h20000, -32'sh10000, 0, 0, 65536, 3)});
    // Weight widths outside 1..4 are clamped.
    table_q.push_back('{mk(CMD_SET_KIND, 0, 0, 0, 0, 0, 0, 0, KIND_WEIGHT, 0), 0,
                        '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 0, 32'h4000), 1, res(32'h4000, 0, 0, 0, 0, 32'h4000, 1)});
    table_q.push_back('{mk(CMD_SET_KIND, 0, 0, 0, 0, 0, 0, 0, KIND_WEIGHT, 7), 0,
                        '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 0, 32'h8000), 1,
                        res(32'h8000, 32'h10000, -32'sh8000, 32'h3fffffff, 0, 32'h8000, 4)});
    // An unknown kind leaves the channel as it was.
    table_q.push_back('{mk(CMD_SET_KIND, 0, 0, 0, 0, 0, 0, 0, 3, 2), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 0, 32'h10000), 1,
                        res(32'h10000, 32'h20000, -32'sh10000, 32'h7fffffff, 0, 65536, 4)});
    table_q.push_back('{mk(CMD_LOAD_VEC, 0, 1, 0, 32'h10000, 0, 0, 0), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_LOAD_VEC, 1, 1, 0, 0, 32'h10000, 0, 0), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_SET_KIND, 0, 1, 0, 0, 0, 0, 0, KIND_ORIENT, 0), 0,
                        '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 1, 32'h8000), 0, '{default: '0}});
    // Opposite quaternions hit the full-cosine case.
    table_q.push_back('{mk(CMD_LOAD_VEC, 1, 1, 0, -32'sh10000, 0, 0, 0), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 1, 32'h8000), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_LOAD_VEC, 1, 1, 0, 30000, -30000, 30000, 40000), 0,
                        '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 1, 32'h4000), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_LOAD_VEC, 1, 1, 0, -64'sd2147483648, 64'sd2147483647,
                           -64'sd2147483648, 64'sd2147483647), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 1, 32'hC000), 0, '{default: '0}});
    // Equal key times give a zero span, so the fraction is one.
    table_q.push_back('{mk(CMD_LOAD_TIME, 1, 0, 0), 0, '{default: '0}});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 0, 0), 1,
                        res(32'h10000, 32'h20000, -32'sh10000, 32'h7fffffff, 0, 65536, 4)});
    table_q.push_back('{mk(CMD_SAMPLE, 0, 0, -1), 1, res(0, 0, 0, 0, 0, 0, 4)});
    foreach (table_q[i]) send_word(table_q[i].w, table_q[i].known, table_q[i].r);

    for (int p = 0; p < 8; p++) begin
      drain();
      if (p == 3) begin snd_idle = 59; rcv_idle = 19; end
      if (p == 6) begin snd_idle = 0; rcv_idle = 0; end
      reg_write(REG_MODE, phase_mode[p]);
      reg_write(REG_COUNT, phase_cnt[p]);
      @(posedge clk_i);
      if (p == 0) hold_from = cyc + 5;
      n = (phase_cnt[p] < 2) ? 2 : phase_cnt[p];
      // Mostly ascending key times, with an occasional equal or backward step.
      tt = longint'($urandom_range(200000)) - 100000;
      for (int s = 0; s < n; s++) begin
        send_word(mk(CMD_LOAD_TIME, s, 0, tt));
        sel = $urandom_range(19);
        if (sel == 0) tt = tt - $urandom_range(65536);
        else if (sel != 1) tt = tt + 1 + $urandom_range(32'h20000);
      end
      for (int it = 0; it < phase_len[p]; it++) begin
        sel = $urandom_range(99);
        k = $urandom_range(n - 1);
        if (sel < 65) begin
          tt = key_time[k] + longint'($urandom_range(32'h20000)) - 32'h8000;
          w = mk(CMD_SAMPLE, $urandom_range(255), $urandom_range(15), tt, $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom_range(3), $urandom_range(7));
        end else if (sel < 70) begin
          w = mk(CMD_SAMPLE, 0, $urandom_range(15), $signed($urandom()));
        end else if (sel < 85) begin
          w = rnd_vec(k, $urandom_range(15));
        end else if (sel < 93) begin
          w = mk(CMD_SET_KIND, $urandom_range(255), $urandom_range(15), 0, 0, 0, 0, 0,
                 $urandom_range(3), $urandom_range(7));
        end else begin
          w = mk(CMD_LOAD_TIME, $urandom_range(255), $urandom_range(15), $signed($urandom()));
        end
        send_word(w);
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
